// ===== rtl/sirt_pkg.sv =====
// Shared constants, types and symbol lookup for the radix text converter.
package sirt_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int DIGIT_DEPTH = 32;
    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int SYM_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 6;
    localparam int ADDR_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS   = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
    localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'h0000000000003938;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [RADIX_W-1:0]   remainder;
    } div_result_t;

    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [SYM_W-1:0]   low,
        input logic [SYM_W-1:0]   high,
        input logic [DIGIT_W-1:0] k
    );
        logic [SYM_W-1:0] word;
        word = k[DIGIT_W-1] ? high : low;
        return word[k[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== rtl/sirt_alpha_check.sv =====
// Alphabet validity check over the configured radix and symbol registers.
module sirt_alpha_check (
    input  logic [sirt_pkg::RADIX_W-1:0] radix,
    input  logic [sirt_pkg::SYM_W-1:0]   symbols_low,
    input  logic [sirt_pkg::SYM_W-1:0]   symbols_high,
    output logic                         ok
);

    logic [sirt_pkg::CHAR_W-1:0] sym [sirt_pkg::MAX_RADIX];
    logic                        bad_sym;
    logic                        dup;
    logic                        range_ok;

    always_comb
    begin
        for (int i = 0; i < sirt_pkg::MAX_RADIX; i++)
        begin
            sym[i] = sirt_pkg::symbol_at(symbols_low, symbols_high,
                                         sirt_pkg::DIGIT_W'(i));
        end
    end

    always_comb
    begin
        bad_sym = 1'b0;
        dup     = 1'b0;
        for (int i = 0; i < sirt_pkg::MAX_RADIX; i++)
        begin
            if ((sirt_pkg::RADIX_W'(i) < radix) &&
                ((sym[i] == sirt_pkg::CHAR_PLUS) || (sym[i] == sirt_pkg::CHAR_MINUS)))
            begin
                bad_sym = 1'b1;
            end
            for (int j = i + 1; j < sirt_pkg::MAX_RADIX; j++)
            begin
                if ((sirt_pkg::RADIX_W'(j) < radix) && (sym[i] == sym[j]))
                begin
                    dup = 1'b1;
                end
            end
        end
    end

    assign range_ok = (radix >= sirt_pkg::RADIX_W'(2)) &&
                      (radix <= sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));
    assign ok = range_ok && !bad_sym && !dup;

endmodule

// ===== rtl/sirt_divider.sv =====
// Iterative divider of a 32-bit magnitude by the radix, eight quotient bits per cycle.
module sirt_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sirt_pkg::VALUE_W-1:0]  dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]  divisor,
    output sirt_pkg::div_result_t         result
);

    logic [sirt_pkg::VALUE_W-1:0]       quo_reg;
    logic [sirt_pkg::VALUE_W-1:0]       quo_next;
    logic [sirt_pkg::RADIX_W-1:0]       rem_reg;
    logic [sirt_pkg::RADIX_W-1:0]       rem_next;
    logic [sirt_pkg::STEP_CNT_W-1:0]    cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    always_comb
    begin
        logic [sirt_pkg::RADIX_W-1:0]       r;
        logic [sirt_pkg::RADIX_W:0]         t;
        logic [sirt_pkg::BITS_PER_STEP-1:0] q;
        r = rem_reg;
        q = '0;
        for (int i = 0; i < sirt_pkg::BITS_PER_STEP; i++)
        begin
            t = {r, quo_reg[sirt_pkg::VALUE_W-1-i]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
                q[sirt_pkg::BITS_PER_STEP-1-i] = 1'b1;
            end
            r = t[sirt_pkg::RADIX_W-1:0];
        end
        rem_next = r;
        quo_next = {quo_reg[sirt_pkg::VALUE_W-sirt_pkg::BITS_PER_STEP-1:0], q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == sirt_pkg::STEP_CNT_W'(sirt_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== rtl/signed_integer_to_radix_text.sv =====
// Top level: signed integer to radix text converter with digit stack and sequencer.
// Converts one signed 32-bit value per request into its text in the configured
// radix, one character per output request, most significant first, with a
// leading '-' for negatives and last on the final character. An invalid
// alphabet gives a single request with bad_alphabet set and char_code 0.
// Sequence: each digit above the least significant one takes a decision step,
// four 8-bit division steps on the shared divider and a store of the digit;
// the final digit is stored in the decision step itself, a negative value
// adds a sign character, and each character passes through the digit stack's
// registered read port. The block takes no new request until the last
// character has been loaded into the output register and that register is
// empty or being drained. Configuration writes are accepted every cycle.
module signed_integer_to_radix_text (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sirt_pkg::SYM_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [sirt_pkg::VALUE_W-1:0] value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]     char_code,
    output logic                            last,
    output logic                            bad_alphabet
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [sirt_pkg::RADIX_W-1:0]     radix_reg;
    logic [sirt_pkg::SYM_W-1:0]       sym_low_reg;
    logic [sirt_pkg::SYM_W-1:0]       sym_high_reg;
    logic [sirt_pkg::VALUE_W-1:0]     mag_reg;
    logic [sirt_pkg::VALUE_W-1:0]     mag_next;
    logic                             neg_reg;
    logic [sirt_pkg::COUNT_W-1:0]     count_reg;
    logic [sirt_pkg::COUNT_W-1:0]     count_next;
    logic                             out_valid_reg;
    logic [sirt_pkg::CHAR_W-1:0]      char_reg;
    logic                             last_reg;
    logic                             bad_reg;
    logic [sirt_pkg::DIGIT_W-1:0]     rd_data_reg;
    logic [sirt_pkg::DIGIT_W-1:0]     stack_mem [sirt_pkg::DIGIT_DEPTH];

    logic                             alpha_ok;
    logic                             in_fire;
    logic                             out_free;
    logic                             more_digits;
    logic                             div_start;
    sirt_pkg::div_result_t            div_res;
    logic                             wr_en;
    logic [sirt_pkg::DIGIT_W-1:0]     wr_data;
    logic                             rd_en;
    logic [sirt_pkg::ADDR_W-1:0]      rd_addr;
    logic                             load_out;
    logic [sirt_pkg::CHAR_W-1:0]      load_char;
    logic                             load_last;
    logic                             load_bad;

    sirt_alpha_check u_check (
        .radix        (radix_reg),
        .symbols_low  (sym_low_reg),
        .symbols_high (sym_high_reg),
        .ok           (alpha_ok)
    );

    sirt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (radix_reg),
        .result   (div_res)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign more_digits = (mag_reg >= {{(sirt_pkg::VALUE_W-sirt_pkg::RADIX_W){1'b0}}, radix_reg})
                      && (count_reg < sirt_pkg::COUNT_W'(sirt_pkg::DIGIT_DEPTH - 1));
    assign rd_addr = sirt_pkg::ADDR_W'(count_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        count_next = count_reg;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        wr_data    = mag_reg[sirt_pkg::DIGIT_W-1:0];
        rd_en      = 1'b0;
        load_out   = 1'b0;
        load_char  = sirt_pkg::CHAR_NONE;
        load_last  = 1'b0;
        load_bad   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!alpha_ok)
                    begin
                        load_out  = 1'b1;
                        load_last = 1'b1;
                        load_bad  = 1'b1;
                    end
                    else
                    begin
                        mag_next   = value[sirt_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
                        count_next = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (more_digits)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = neg_reg ? S_SIGN : S_READ;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = div_res.remainder[sirt_pkg::DIGIT_W-1:0];
                    mag_next   = div_res.quotient;
                    count_next = count_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_char  = sirt_pkg::CHAR_MINUS;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_char  = sirt_pkg::symbol_at(sym_low_reg, sym_high_reg, rd_data_reg);
                    load_last  = (count_reg == '0);
                    state_next = (count_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= sirt_pkg::RADIX_RESET;
            sym_low_reg   <= sirt_pkg::SYMBOLS_LOW_RESET;
            sym_high_reg  <= sirt_pkg::SYMBOLS_HIGH_RESET;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
            count_reg <= count_next;
            if (in_fire)
            begin
                neg_reg <= value[sirt_pkg::VALUE_W-1];
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sirt_pkg::CFG_RADIX:
                    begin
                        radix_reg <= cfg_data[sirt_pkg::RADIX_W-1:0];
                    end
                    sirt_pkg::CFG_SYMBOLS_LOW:
                    begin
                        sym_low_reg <= cfg_data;
                    end
                    sirt_pkg::CFG_SYMBOLS_HIGH:
                    begin
                        sym_high_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            char_reg <= load_char;
            last_reg <= load_last;
            bad_reg  <= load_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[count_reg[sirt_pkg::ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_reg;
    assign last         = last_reg;
    assign bad_alphabet = bad_reg;

endmodule
